// ----- rtl/core/ovn_pkg.sv -----
// ----------------------------------------------------------------------------
// ovn_pkg
// Shared types and constants for the octave value noise block.
// ----------------------------------------------------------------------------
package ovn_pkg;

  localparam int SIDE_LOG2_DEF   = 5;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int POS_W     = 5;
  localparam int SAMPLE_W  = 16;
  localparam int NOISE_W   = 16;
  localparam int OCT_W     = 3;
  localparam int BIAS_W    = 17;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 17;
  localparam int WEIGHT_FRAC = 16;

  localparam logic [CFG_IDX_W-1:0] REG_OCTAVES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS    = 2'd1;

  localparam logic [OCT_W-1:0]  OCT_RESET  = 3'd5;
  localparam logic [BIAS_W-1:0] BIAS_RESET = 17'd32768;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam int FQ_DEPTH = 2;

  typedef struct packed {
    logic                req_type;
    logic [POS_W-1:0]    pos_x;
    logic [POS_W-1:0]    pos_y;
    logic [SAMPLE_W-1:0] seed_sample;
  } req_t;

  typedef struct packed {
    logic [POS_W-1:0]   out_x;
    logic [POS_W-1:0]   out_y;
    logic [NOISE_W-1:0] noise_value;
  } res_t;

  typedef struct packed {
    logic take;
    logic load;
  } back_stat_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_RD,
    B_WT,
    B_SUM,
    B_DIV,
    B_OUT
  } back_state_t;

endpackage

// ----- rtl/core/ovn_ram.sv -----
// ----------------------------------------------------------------------------
// ovn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ovn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/ovn_front.sv -----
// ----------------------------------------------------------------------------
// ovn_front
// Input side: accepts request transactions into a short queue for the back end.
// ----------------------------------------------------------------------------
module ovn_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ovn_pkg::req_t request,
  output logic          full,
  output logic          cmd_valid,
  output ovn_pkg::req_t cmd,
  input  logic          cmd_take
);

  ovn_pkg::req_t slots [ovn_pkg::FQ_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full      = (count == 2'(ovn_pkg::FQ_DEPTH));
  assign cmd_valid = (count != 2'd0);
  assign cmd       = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= request;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// ----- rtl/core/ovn_back.sv -----
// ----------------------------------------------------------------------------
// ovn_back
// Back end: seed writes, octave accumulation, serial divide and result register.
// ----------------------------------------------------------------------------
module ovn_back #(
  parameter int SIDE_LOG2   = ovn_pkg::SIDE_LOG2_DEF,
  parameter int SAMPLE_BITS = ovn_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [ovn_pkg::OCT_W-1:0]        octave_count,
  input  logic [ovn_pkg::BIAS_W-1:0]       inverse_bias,
  input  logic                             cmd_valid,
  input  ovn_pkg::req_t                    cmd,
  output ovn_pkg::back_stat_t              stat,
  output logic                             ram_we,
  output logic [2*SIDE_LOG2-1:0]           ram_waddr,
  output logic [SAMPLE_BITS-1:0]           ram_wdata,
  output logic [2*SIDE_LOG2-1:0]           ram_raddr,
  input  logic [SAMPLE_BITS-1:0]           ram_rdata,
  input  logic                             pop,
  output logic                             empty,
  output ovn_pkg::res_t                    result
);

  localparam int CW   = SIDE_LOG2;
  localparam int GW   = SIDE_LOG2 + 1;
  localparam int KW   = 2 * SIDE_LOG2 + 1;
  localparam int PW   = SAMPLE_BITS + KW;
  localparam int ACCW = PW + 2;
  localparam int WW   = ovn_pkg::WEIGHT_FRAC + 1 + SIDE_LOG2;
  localparam int WPW  = WW + ovn_pkg::BIAS_W;
  localparam int VWW  = SAMPLE_BITS + WW;
  localparam int NUMW = VWW + 4;
  localparam int DENW = WW + 4;
  localparam int DCW  = $clog2(SAMPLE_BITS + 1);
  localparam logic [3:0] OCT_MAX = 4'(SIDE_LOG2 + 1);

  ovn_pkg::back_state_t state, state_next;

  logic [CW-1:0]          qx, qy;
  logic [3:0]             octs, oct;
  logic [2:0]             step;
  logic [KW-1:0]          coef_r;
  logic [PW-1:0]          prod_r;
  logic [ACCW-1:0]        acc;
  logic [VWW-1:0]         vw_r;
  logic [WPW-1:0]         wprod_r;
  logic [WW-1:0]          weight;
  logic [NUMW-1:0]        num, rem, dsh;
  logic [DENW-1:0]        den;
  logic [SAMPLE_BITS-1:0] quo;
  logic [DCW-1:0]         dcnt;
  logic                   res_valid;

  logic [31:0]       px_w, py_w, sx_w;
  logic [3:0]        oct_lim, shift;
  logic [31:0]       msk_w;
  logic [CW-1:0]     msk, fx, fy, x1, y1, x2, y2, cx, cy;
  logic [GW-1:0]     span, gx, gy, ax, ay;
  logic [CW:0]       x2_w, y2_w;
  logic [ACCW-1:0]   v_full;
  logic [NUMW-1:0]   num_sum, div_diff;
  logic [DENW-1:0]   den_sum;
  logic              ge;
  logic              is_query, take, load;
  logic [31:0]       q_w, ox_w, oy_w;

  assign px_w = 32'(cmd.pos_x);
  assign py_w = 32'(cmd.pos_y);
  assign sx_w = 32'(cmd.seed_sample);

  assign is_query = (cmd.req_type == ovn_pkg::REQ_QUERY);
  assign take     = (state == ovn_pkg::B_IDLE) && cmd_valid;
  assign load     = (state == ovn_pkg::B_OUT) && (!res_valid || pop);
  assign stat     = '{take: take, load: load};

  assign ram_we    = take && !is_query;
  assign ram_waddr = {py_w[CW-1:0], px_w[CW-1:0]};
  assign ram_wdata = sx_w[SAMPLE_BITS-1:0];

  always_comb begin
    oct_lim = {1'b0, octave_count};
    if (oct_lim == 4'd0) begin
      oct_lim = 4'd1;
    end
    if (oct_lim > OCT_MAX) begin
      oct_lim = OCT_MAX;
    end
  end

  // corner geometry for the current octave
  assign shift = 4'(SIDE_LOG2) - oct;
  assign msk_w = (32'd1 << shift) - 32'd1;
  assign msk   = msk_w[CW-1:0];
  assign span  = GW'(msk_w[GW-1:0]) + GW'(1);
  assign fx    = qx & msk;
  assign fy    = qy & msk;
  assign x1    = qx & ~msk;
  assign y1    = qy & ~msk;
  assign x2_w  = (CW+1)'(x1) + span;
  assign y2_w  = (CW+1)'(y1) + span;
  assign x2    = x2_w[CW-1:0];
  assign y2    = y2_w[CW-1:0];
  assign gx    = span - GW'(fx);
  assign gy    = span - GW'(fy);

  always_comb begin
    case (step[1:0])
      2'd0: begin cx = x1; cy = y1; ax = gx;      ay = gy;      end
      2'd1: begin cx = x2; cy = y1; ax = GW'(fx); ay = gy;      end
      2'd2: begin cx = x1; cy = y2; ax = gx;      ay = GW'(fy); end
      default: begin cx = x2; cy = y2; ax = GW'(fx); ay = GW'(fy); end
    endcase
  end

  assign ram_raddr = {cy, cx};

  assign v_full   = acc >> {shift, 1'b0};
  assign num_sum  = num + NUMW'(vw_r);
  assign den_sum  = den + DENW'(weight);
  assign div_diff = rem - dsh;
  assign ge       = (rem >= dsh);

  always_comb begin
    state_next = state;
    case (state)
      ovn_pkg::B_IDLE: begin
        if (cmd_valid && is_query) begin
          state_next = ovn_pkg::B_RD;
        end
      end
      ovn_pkg::B_RD: begin
        if (step == 3'd5) begin
          state_next = ovn_pkg::B_WT;
        end
      end
      ovn_pkg::B_WT: state_next = ovn_pkg::B_SUM;
      ovn_pkg::B_SUM: begin
        if (oct + 4'd1 == octs) begin
          state_next = ovn_pkg::B_DIV;
        end else begin
          state_next = ovn_pkg::B_RD;
        end
      end
      ovn_pkg::B_DIV: begin
        if (dcnt == DCW'(SAMPLE_BITS - 1)) begin
          state_next = ovn_pkg::B_OUT;
        end
      end
      ovn_pkg::B_OUT: begin
        if (load) begin
          state_next = ovn_pkg::B_IDLE;
        end
      end
      default: state_next = ovn_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ovn_pkg::B_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        res_valid <= 1'b1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ovn_pkg::B_IDLE: begin
        qx     <= px_w[CW-1:0];
        qy     <= py_w[CW-1:0];
        octs   <= oct_lim;
        oct    <= 4'd0;
        step   <= 3'd0;
        acc    <= '0;
        num    <= '0;
        den    <= '0;
        weight <= WW'(1 << ovn_pkg::WEIGHT_FRAC);
      end
      ovn_pkg::B_RD: begin
        coef_r <= KW'(ax) * KW'(ay);
        prod_r <= PW'(ram_rdata) * PW'(coef_r);
        if (step >= 3'd2) begin
          acc <= acc + ACCW'(prod_r);
        end
        step <= step + 3'd1;
      end
      ovn_pkg::B_WT: begin
        vw_r    <= VWW'(v_full[SAMPLE_BITS-1:0]) * VWW'(weight);
        wprod_r <= WPW'(weight) * WPW'(inverse_bias);
      end
      ovn_pkg::B_SUM: begin
        num    <= num_sum;
        den    <= den_sum;
        weight <= wprod_r[WW+ovn_pkg::WEIGHT_FRAC-1:ovn_pkg::WEIGHT_FRAC];
        oct    <= oct + 4'd1;
        step   <= 3'd0;
        acc    <= '0;
        rem    <= num_sum;
        dsh    <= NUMW'(den_sum) << (SAMPLE_BITS - 1);
        dcnt   <= '0;
      end
      ovn_pkg::B_DIV: begin
        if (ge) begin
          rem <= div_diff;
        end
        quo  <= {quo[SAMPLE_BITS-2:0], ge};
        dsh  <= dsh >> 1;
        dcnt <= dcnt + DCW'(1);
      end
      default: begin
      end
    endcase
  end

  assign q_w  = 32'(quo);
  assign ox_w = 32'(qx);
  assign oy_w = 32'(qy);

  always_ff @(posedge clk) begin
    if (load) begin
      result.out_x       <= ox_w[ovn_pkg::POS_W-1:0];
      result.out_y       <= oy_w[ovn_pkg::POS_W-1:0];
      result.noise_value <= q_w[ovn_pkg::NOISE_W-1:0];
    end
  end

  assign empty = !res_valid;

endmodule

// ----- rtl/core/octave_value_noise_2d.sv -----
// ----------------------------------------------------------------------------
// octave_value_noise_2d
// Octave value noise over a square seed grid held in RAM.
// ----------------------------------------------------------------------------
// A write passes from the request queue to the RAM when the back end takes
// it. A query runs, for each octave, four corner reads through the single
// RAM read port feeding one multiply-accumulate, then a weight update; then
// a restoring divide yields SAMPLE_BITS quotient bits for the result
// register. A 2-entry request queue lets the next transactions be pushed
// while a query runs; one result register holds the finished result until
// popped.
module octave_value_noise_2d #(
  parameter int SIDE_LOG2   = ovn_pkg::SIDE_LOG2_DEF,
  parameter int SAMPLE_BITS = ovn_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  ovn_pkg::req_t                   request,
  output logic                            full,
  output logic                            empty,
  input  logic                            pop,
  output ovn_pkg::res_t                   result,
  input  logic                            cfg_we,
  input  logic [ovn_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ovn_pkg::CFG_DAT_W-1:0]   cfg_data
);

  logic [ovn_pkg::OCT_W-1:0]  octave_count;
  logic [ovn_pkg::BIAS_W-1:0] inverse_bias;

  logic                 cmd_valid;
  ovn_pkg::req_t        cmd;
  ovn_pkg::back_stat_t  stat;

  logic                   ram_we;
  logic [2*SIDE_LOG2-1:0] ram_waddr, ram_raddr;
  logic [SAMPLE_BITS-1:0] ram_wdata, ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      octave_count <= ovn_pkg::OCT_RESET;
      inverse_bias <= ovn_pkg::BIAS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ovn_pkg::REG_OCTAVES: octave_count <= cfg_data[ovn_pkg::OCT_W-1:0];
        ovn_pkg::REG_BIAS:    inverse_bias <= cfg_data[ovn_pkg::BIAS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ovn_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .request   (request),
    .full      (full),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (stat.take)
  );

  ovn_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (1 << (2 * SIDE_LOG2))
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ovn_back #(
    .SIDE_LOG2   (SIDE_LOG2),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .octave_count (octave_count),
    .inverse_bias (inverse_bias),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .stat         (stat),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata),
    .pop          (pop),
    .empty        (empty),
    .result       (result)
  );

`ifndef SYNTH
  a_reset_clear: assert property (@(posedge clk) $past(rst) |-> (empty && !full))
    else $error("queues not clear after reset");
  a_take_valid: assert property (@(posedge clk) disable iff (rst) stat.take |-> cmd_valid)
    else $error("back end took from an empty queue");
  a_load_free: assert property (@(posedge clk) disable iff (rst) stat.load |-> (empty || pop))
    else $error("result overwritten before pop");
`endif

endmodule
